// ===== rtl/msc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_pkg: shared definitions for the checked-pop multi-stack
// Field widths, status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package msc_pkg;

   localparam int unsigned COMMAND_W = 1;
   localparam int unsigned SECTION_W = 4;
   localparam int unsigned VALUE_W   = 16;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned LOAD_W    = 13;
   localparam int unsigned ACTIVE_W  = 5;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 13;

   localparam int unsigned NUM_SECTIONS_DEF  = 16;
   localparam int unsigned SECTION_DEPTH_DEF = 256;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STAT_OK          = 3'd0;
   localparam status_type STAT_BAD_SECTION = 3'd1;
   localparam status_type STAT_CAPACITY    = 3'd2;
   localparam status_type STAT_FULL        = 3'd3;
   localparam status_type STAT_MISMATCH    = 3'd4;

   localparam logic [COMMAND_W-1:0] CMD_PUSH = 1'b0;
   localparam logic [COMMAND_W-1:0] CMD_POP  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SECTIONS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY        = 1'b1;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET   = 5'd16;
   localparam logic [LOAD_W-1:0]   CAPACITY_RESET = 13'd4096;

endpackage : msc_pkg
`default_nettype wire

// ===== rtl/msc_height_tab.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_height_tab: per-section height table
// Synchronous memory of section heights with one valid bit per section;
// a section never written since reset reads as empty.
// ----------------------------------------------------------------------------
module msc_height_tab #(
   parameter int unsigned NUM_SECTIONS = 16,
   parameter int unsigned IDX_W        = 4,
   parameter int unsigned HGT_W        = 9
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_idx,
   output logic      [HGT_W-1:0] rd_height,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire logic [HGT_W-1:0] wr_height
);

   logic [HGT_W-1:0]        hgt_mem [NUM_SECTIONS];
   logic [NUM_SECTIONS-1:0] valid_ff;
   logic [HGT_W-1:0]        rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hgt_mem[wr_idx] <= wr_height;
      end
      if (rd_en) begin
         rd_data_ff <= hgt_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_height = rd_valid_ff ? rd_data_ff : '0;

endmodule : msc_height_tab
`default_nettype wire

// ===== rtl/multi_stack_checked_pop.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stack_checked_pop: several LIFO sections sharing one item limit
// Request beats push a tag onto a section or pop it when the top matches.
// Each request beat yields exactly one response beat carrying a status code,
// the total load, its peak since reset, an all-empty flag and a sticky error
// flag. A failing request leaves stacks, load and peak untouched.
// The block works on one request at a time: the idle state takes the beat
// and reads the section height, the height state reads the top entry of the
// stack memory and the top state checks and writes back; req_stall is high
// in the height and top states. The response is registered, so the next
// request is taken while a response beat still waits. If rsp_stall holds an
// earlier response, the check-and-write cycle waits until that beat leaves.
// csr_index 0 sets the number of active sections, 1 the capacity; write
// only while no request is in flight.
// Reset clears heights (through valid bits), load, peak, the error flag and
// restores active sections to 16 and capacity to 4096; no clearing pass.
// ----------------------------------------------------------------------------
module multi_stack_checked_pop #(
   parameter int unsigned NUM_SECTIONS  = msc_pkg::NUM_SECTIONS_DEF,
   parameter int unsigned SECTION_DEPTH = msc_pkg::SECTION_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [msc_pkg::COMMAND_W-1:0]   req_command,
   input  wire logic [msc_pkg::SECTION_W-1:0]   req_section,
   input  wire logic [msc_pkg::VALUE_W-1:0]     req_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [msc_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [msc_pkg::LOAD_W-1:0]      rsp_load,
   output logic      [msc_pkg::LOAD_W-1:0]      rsp_peak,
   output logic                                 rsp_all_empty,
   output logic                                 rsp_error_seen,
   input  wire logic                            csr_write_en,
   input  wire logic [msc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [msc_pkg::CSR_DAT_W-1:0]   csr_write_data
);

   import msc_pkg::*;

   localparam int unsigned MEM_DEPTH = NUM_SECTIONS * SECTION_DEPTH;
   localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int unsigned HGT_W     = $clog2(SECTION_DEPTH + 1);
   localparam int unsigned IDX_W     = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

   localparam logic [1:0] FSM_IDLE = 2'd0;
   localparam logic [1:0] FSM_HGT  = 2'd1;
   localparam logic [1:0] FSM_TOP  = 2'd2;

   // configuration
   logic [ACTIVE_W-1:0] active_ff;
   logic [LOAD_W-1:0]   capacity_ff;

   // sequencer and item registers
   logic [1:0]           state_ff, state_in;
   logic [COMMAND_W-1:0] command_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 bad_ff;
   logic [ADDR_W-1:0]    base_ff;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [HGT_W-1:0]     hgt_ff;

   // counters
   logic [LOAD_W-1:0] load_ff, load_in;
   logic [LOAD_W-1:0] peak_ff, peak_in;
   logic              error_ff;

   // response register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LOAD_W-1:0]   rsp_load_ff;
   logic [LOAD_W-1:0]   rsp_peak_ff;
   logic                rsp_all_empty_ff;
   logic                rsp_error_ff;

   logic [VALUE_W-1:0] stack_mem [MEM_DEPTH];
   logic [VALUE_W-1:0] top_ff;

   logic                  req_beat;
   logic                  rsp_beat;
   logic [IDX_W+SECTION_W-1:0] sec_wide;
   logic [IDX_W-1:0]      sec_idx;
   logic                  sec_bad;
   logic [HGT_W-1:0]      hgt_rd;
   logic                  top_rd_en;
   logic                  commit;
   status_type            status;
   logic                  push_ok;
   logic                  pop_ok;
   logic                  hgt_wr_en;
   logic [HGT_W-1:0]      hgt_wr;

   assign req_stall = (state_ff != FSM_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid_ff && !rsp_stall;

   assign sec_wide = {{IDX_W{1'b0}}, req_section};
   assign sec_idx  = sec_wide[IDX_W-1:0];
   assign sec_bad  = ({1'b0, req_section} >= active_ff)
                   || (32'(req_section) >= 32'(NUM_SECTIONS));

   msc_height_tab #(
      .NUM_SECTIONS (NUM_SECTIONS),
      .IDX_W        (IDX_W),
      .HGT_W        (HGT_W)
   ) u_height (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_beat && !sec_bad),
      .rd_idx    (sec_idx),
      .rd_height (hgt_rd),
      .wr_en     (hgt_wr_en),
      .wr_idx    (idx_ff),
      .wr_height (hgt_wr)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= ACTIVE_RESET;
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ACTIVE_SECTIONS: active_ff   <= csr_write_data[ACTIVE_W-1:0];
            CSR_CAPACITY:        capacity_ff <= csr_write_data[LOAD_W-1:0];
            default: ;
         endcase
      end
   end

   // capture the request beat
   always_ff @(posedge clock) begin
      if (req_beat) begin
         command_ff <= req_command;
         value_ff   <= req_value;
         idx_ff     <= sec_idx;
         bad_ff     <= sec_bad;
         base_ff    <= ADDR_W'(sec_idx * SECTION_DEPTH);
      end
      if (state_ff == FSM_HGT) begin
         hgt_ff  <= hgt_rd;
         addr_ff <= addr_in;
      end
   end

   always_comb begin
      if (command_ff == CMD_POP) begin
         addr_in = base_ff + ADDR_W'(hgt_rd - 1'b1);
      end else begin
         addr_in = base_ff + ADDR_W'(hgt_rd);
      end
   end

   assign top_rd_en = (state_ff == FSM_HGT) && !bad_ff && (command_ff == CMD_POP)
                    && (hgt_rd != '0);

   // check the beat against section, height, capacity and top entry
   always_comb begin
      push_ok = 1'b0;
      pop_ok  = 1'b0;
      priority if (bad_ff) begin
         status = STAT_BAD_SECTION;
      end else if (command_ff == CMD_PUSH) begin
         priority if (load_ff >= capacity_ff) begin
            status = STAT_CAPACITY;
         end else if (hgt_ff == HGT_W'(SECTION_DEPTH)) begin
            status = STAT_FULL;
         end else begin
            status  = STAT_OK;
            push_ok = 1'b1;
         end
      end else begin
         if ((hgt_ff == '0) || (top_ff != value_ff)) begin
            status = STAT_MISMATCH;
         end else begin
            status = STAT_OK;
            pop_ok = 1'b1;
         end
      end
   end

   assign commit    = (state_ff == FSM_TOP) && (!rsp_valid_ff || !rsp_stall);
   assign hgt_wr_en = commit && (push_ok || pop_ok);
   assign hgt_wr    = push_ok ? HGT_W'(hgt_ff + 1'b1) : HGT_W'(hgt_ff - 1'b1);

   always_comb begin
      load_in = load_ff;
      peak_in = peak_ff;
      if (push_ok) begin
         load_in = load_ff + 1'b1;
      end else if (pop_ok && (load_ff != '0)) begin
         load_in = load_ff - 1'b1;
      end
      if (load_in > peak_ff) begin
         peak_in = load_in;
      end
   end

   // stack memory: read the top in the height cycle, write on a good push
   always_ff @(posedge clock) begin
      if (commit && push_ok) begin
         stack_mem[addr_ff] <= value_ff;
      end
      if (top_rd_en) begin
         top_ff <= stack_mem[addr_in];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: if (req_beat) state_in = FSM_HGT;
         FSM_HGT:  state_in = FSM_TOP;
         FSM_TOP:  if (commit) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         load_ff      <= '0;
         peak_ff      <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            load_ff      <= load_in;
            peak_ff      <= peak_in;
            error_ff     <= error_ff || (status != STAT_OK);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_beat) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload: hold while stalled
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff    <= status;
         rsp_load_ff      <= load_in;
         rsp_peak_ff      <= peak_in;
         rsp_all_empty_ff <= (load_in == '0);
         rsp_error_ff     <= error_ff || (status != STAT_OK);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_load       = rsp_load_ff;
   assign rsp_peak       = rsp_peak_ff;
   assign rsp_all_empty  = rsp_all_empty_ff;
   assign rsp_error_seen = rsp_error_ff;

   a_peak_covers_load: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= load_ff)
      else $error("peak below current load");

   a_load_within_memory: assert property (@(posedge clock) disable iff (reset)
      32'(load_ff) <= 32'(MEM_DEPTH))
      else $error("load exceeds stack memory size");

   a_failure_is_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STAT_OK) |-> rsp_error_ff && error_ff)
      else $error("failed beat without error flag");

   a_empty_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_all_empty_ff == (rsp_load_ff == '0)))
      else $error("all-empty flag disagrees with load");

   a_commit_only_from_top: assert property (@(posedge clock) disable iff (reset)
      hgt_wr_en |-> (state_ff == FSM_TOP) && !bad_ff)
      else $error("height write outside check cycle");

endmodule : multi_stack_checked_pop
`default_nettype wire
